FILE: sv/lpht_pkg.sv
// Shared types and constants for the linear-probing hash table core.
// Field widths, action/status/slot-mark codes and parameter defaults.
// No dependencies.
`default_nettype none

package lpht_pkg;

	// parameter defaults
	localparam int TABLE_DEPTH_DEF   = 1024;
	localparam int KEY_WIDTH_DEF     = 32;
	localparam int VALUE_WIDTH_DEF   = 32;

	// register and field widths
	localparam int LIMIT_W     = 10;
	localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 10'd768;
	localparam int ACTION_W    = 2;
	localparam int HASH_W      = 32;
	localparam int KEY_IN_W    = 32;
	localparam int VALUE_IN_W  = 32;
	localparam int STATUS_W    = 2;
	localparam int SLOT_W      = 10;
	localparam int VALUE_OUT_W = 32;
	localparam int COUNT_OUT_W = 11;

	// stream word layout
	localparam int IN_DATA_W  = HASH_W + KEY_IN_W + VALUE_IN_W;
	localparam int OUT_DATA_W = SLOT_W + VALUE_OUT_W + 2 * COUNT_OUT_W;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUT    = 2'd0,
		ACT_GET    = 2'd1,
		ACT_REMOVE = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_USED  = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

endpackage

`default_nettype wire

FILE: sv/linear_probe_hash_table_core.sv
// Open-addressing hash table with linear probing and tombstones.
// Slot marks, keys and values sit in three single-port-read synchronous memories.
// Depends on lpht_pkg.
//
// Flow: an accepted item passes through the home-slot reduction in S_MOD (only when
// TABLE_DEPTH is not a power of two), then S_START, the S_PROBE loop and S_DONE, which
// loads the result word; one mark-memory read per probe, and no new item is taken before S_IDLE.
// Early outcomes (table full by load limit, empty table, unused action) need no probe:
// S_START goes straight on to S_DONE.
// A result word still waiting at the output holds the next item in its last state.
// Reset: after arst_n the mark memory is swept to empty, one slot per cycle, and no word
// is accepted during the sweep; cfg writes are always taken.
`default_nettype none

module linear_probe_hash_table_core #(
	parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_WIDTH   = lpht_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = lpht_pkg::VALUE_WIDTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// config: load_limit
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [lpht_pkg::LIMIT_W-1:0]    cfg_data,
	// request
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire  [lpht_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // hash_value, key, value_in
	input  wire  [lpht_pkg::ACTION_W-1:0]   s_axis_tuser,  // action
	// result
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	output logic [lpht_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // slot, value_out, removed_count,
	                                                       // entries_held
	output logic [lpht_pkg::STATUS_W-1:0]   m_axis_tuser   // status
);
	import lpht_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int CmpW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam bit IsPow2 = ((1 << AW) == TABLE_DEPTH);
	localparam logic [AW-1:0] LastSlot = AW'(TABLE_DEPTH - 1);
	localparam logic [AW:0] DepthW = (AW + 1)'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_START,
		S_PROBE,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [AW-1:0]          clr_addr_q;
	logic [LIMIT_W-1:0]     load_limit_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          removed_q;
	logic [ACTION_W-1:0]    action_q;
	logic [HASH_W-1:0]      hash_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [AW-1:0]          pos_q;
	logic [AW-1:0]          probe_n_q;
	logic [1:0]             mod_cnt_q;
	status_t                status_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [VALUE_OUT_W-1:0] vout_q;

	// memories
	mark_t                  mark_mem [TABLE_DEPTH];
	logic [KEY_WIDTH-1:0]   key_mem  [TABLE_DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem  [TABLE_DEPTH];
	mark_t                  mark_rd;
	logic [KEY_WIDTH-1:0]   key_rd;
	logic [VALUE_WIDTH-1:0] val_rd;

	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   mark_we;
	logic [AW-1:0]          mark_waddr;
	mark_t                  mark_wdata;
	logic                   kv_we;

	logic [AW-1:0]          pos_nxt;
	logic [AW-1:0]          rem_nxt;
	logic                   hit_free;
	logic                   hit_empty;
	logic                   key_match;
	logic                   last_probe;
	logic                   probe_stop;
	logic                   early_done;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);

	assign pos_nxt    = (pos_q == LastSlot) ? '0 : pos_q + AW'(1);
	assign hit_free   = (mark_rd != MARK_USED);
	assign hit_empty  = (mark_rd == MARK_EMPTY);
	assign key_match  = (mark_rd == MARK_USED) && (key_rd == key_q);
	assign last_probe = (probe_n_q == LastSlot);

	// home slot reduction for non power-of-two depth, 8 hash bits per cycle
	always_comb begin
		logic [AW:0] r;
		r = {1'b0, pos_q};
		for (int i = 0; i < 8; i++) begin
			r = {r[AW-1:0], hash_q[HASH_W-1-i]};
			if (r >= DepthW)
				r = r - DepthW;
		end
		rem_nxt = r[AW-1:0];
	end

	always_comb begin
		case (action_q)
			ACT_PUT:    early_done = (CmpW'(count_q) >= CmpW'(load_limit_q));
			ACT_GET:    early_done = (count_q == '0);
			ACT_REMOVE: early_done = (count_q == '0);
			default:    early_done = 1'b1;
		endcase
	end

	always_comb begin
		case (action_q)
			ACT_PUT:    probe_stop = hit_free || last_probe;
			ACT_GET:    probe_stop = hit_empty || key_match || last_probe;
			default:    probe_stop = hit_empty || last_probe;
		endcase
	end

	// memory port control
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = pos_q;
		mark_we    = 1'b0;
		mark_waddr = pos_q;
		mark_wdata = MARK_EMPTY;
		kv_we      = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mark_we    = 1'b1;
				mark_waddr = clr_addr_q;
			end
			S_START: begin
				rd_en = !early_done;
			end
			S_PROBE: begin
				// next slot is fetched while this one is evaluated
				rd_en   = !probe_stop;
				rd_addr = pos_nxt;
				if (action_q == ACT_PUT && hit_free) begin
					mark_we    = 1'b1;
					mark_wdata = MARK_USED;
					kv_we      = 1'b1;
				end else if (action_q == ACT_REMOVE && key_match) begin
					mark_we    = 1'b1;
					mark_wdata = MARK_TOMB;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mark_we)
			mark_mem[mark_waddr] <= mark_wdata;
		if (rd_en)
			mark_rd <= mark_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (kv_we)
			key_mem[pos_q] <= key_q;
		if (rd_en)
			key_rd <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (kv_we)
			val_mem[pos_q] <= val_q;
		if (rd_en)
			val_rd <= val_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_addr_q    <= '0;
			load_limit_q  <= LOAD_LIMIT_RST;
			count_q       <= '0;
			removed_q     <= '0;
			action_q      <= '0;
			hash_q        <= '0;
			key_q         <= '0;
			val_q         <= '0;
			pos_q         <= '0;
			probe_n_q     <= '0;
			mod_cnt_q     <= '0;
			status_q      <= ST_MISS;
			slot_q        <= '0;
			vout_q        <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
		end else begin
			if (cfg_valid)
				load_limit_q <= cfg_data;
			// S_DONE sets the output register itself
			if (m_axis_tready && state_q != S_DONE)
				m_axis_tvalid <= 1'b0;

			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LastSlot)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						action_q  <= s_axis_tuser;
						hash_q    <= s_axis_tdata[HASH_W-1:0];
						key_q     <= KEY_WIDTH'(s_axis_tdata[HASH_W +: KEY_IN_W]);
						val_q     <= VALUE_WIDTH'(s_axis_tdata[HASH_W+KEY_IN_W +: VALUE_IN_W]);
						status_q  <= ST_MISS;
						slot_q    <= '0;
						vout_q    <= '0;
						removed_q <= '0;
						probe_n_q <= '0;
						mod_cnt_q <= '0;
						if (IsPow2) begin
							pos_q   <= s_axis_tdata[AW-1:0];
							state_q <= S_START;
						end else begin
							pos_q   <= '0;
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					pos_q     <= rem_nxt;
					hash_q    <= {hash_q[HASH_W-9:0], 8'd0};
					mod_cnt_q <= mod_cnt_q + 2'd1;
					if (mod_cnt_q == 2'd3)
						state_q <= S_START;
				end
				S_START: begin
					if (action_q == ACT_PUT)
						status_q <= ST_FULL;
					state_q <= early_done ? S_DONE : S_PROBE;
				end
				S_PROBE: begin
					if (action_q == ACT_PUT && hit_free) begin
						count_q  <= count_q + CW'(1);
						status_q <= ST_OK;
						slot_q   <= SLOT_W'(pos_q);
					end else if (action_q == ACT_GET && key_match) begin
						status_q <= ST_OK;
						slot_q   <= SLOT_W'(pos_q);
						vout_q   <= VALUE_OUT_W'(val_rd);
					end else if (action_q == ACT_REMOVE && key_match) begin
						count_q   <= count_q - CW'(1);
						removed_q <= removed_q + CW'(1);
						status_q  <= ST_OK;
					end
					if (probe_stop) begin
						state_q <= S_DONE;
					end else begin
						pos_q     <= pos_nxt;
						probe_n_q <= probe_n_q + AW'(1);
					end
				end
				S_DONE: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tuser  <= status_q;
						m_axis_tdata  <= {COUNT_OUT_W'(count_q), COUNT_OUT_W'(removed_q),
						                  vout_q, slot_q};
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_put_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && action_q == ACT_PUT && hit_free)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("put did not raise entry count");

	a_full_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == ST_FULL)
		|-> m_axis_tdata[SLOT_W+VALUE_OUT_W+COUNT_OUT_W-1:0] == '0)
		else $error("full result carries slot, value or removed count");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> !s_axis_tready)
		else $error("request taken during probing");
`endif

endmodule

`default_nettype wire

FILE: test/lpht_checker.sv
`timescale 1ns / 100ps
// Checker for linear_probe_hash_table_core: watches the config, request and result channels.
// Keeps its own copy of the table, predicts each result word and compares field by field.
// Depends on lpht_pkg.

module lpht_checker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_valid,
	input  wire                               cfg_ready,
	input  wire  [lpht_pkg::LIMIT_W-1:0]      cfg_data,
	input  wire                               s_axis_tvalid,
	input  wire                               s_axis_tready,
	input  wire  [lpht_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // hash_value, key, value_in
	input  wire  [lpht_pkg::ACTION_W-1:0]     s_axis_tuser,   // action
	input  wire                               m_axis_tvalid,
	input  wire                               m_axis_tready,
	input  wire  [lpht_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // slot, value_out,
	                                                          // removed_count, entries_held
	input  wire  [lpht_pkg::STATUS_W-1:0]     m_axis_tuser,   // status
	output int                                fail_count,
	output int                                pending
);
	import lpht_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;

	typedef struct {
		status_t                status;
		logic [SLOT_W-1:0]      slot;
		logic [VALUE_OUT_W-1:0] value;
		logic [COUNT_OUT_W-1:0] removed;
		logic [COUNT_OUT_W-1:0] held;
	} reply_t;

	mark_t                  slot_mark [DEPTH];
	logic [KEY_IN_W-1:0]    key_mem [DEPTH];
	logic [VALUE_IN_W-1:0]  value_mem [DEPTH];
	logic [COUNT_OUT_W-1:0] held_count;
	logic [LIMIT_W-1:0]     load_limit;
	reply_t                 replies_due [$];
	reply_t                 want;
	logic [SLOT_W-1:0]      got_slot;
	logic [VALUE_OUT_W-1:0] got_value;
	logic [COUNT_OUT_W-1:0] got_removed;
	logic [COUNT_OUT_W-1:0] got_held;

	// Walks the table from the home slot exactly as the core should and applies the update.
	function automatic reply_t serve_request(input logic [ACTION_W-1:0] act,
			input logic [HASH_W-1:0] hash, input logic [KEY_IN_W-1:0] key,
			input logic [VALUE_IN_W-1:0] val);
		reply_t r;
		int     pos;
		int     n;
		r.status  = ST_MISS;
		r.slot    = '0;
		r.value   = '0;
		r.removed = '0;
		pos = int'(hash % DEPTH);
		case (act)
		ACT_PUT: begin
			r.status = ST_FULL;
			if (held_count < load_limit) begin
				for (n = 0; n < DEPTH; n++) begin
					if (slot_mark[pos] != MARK_USED) begin
						slot_mark[pos] = MARK_USED;
						key_mem[pos]   = key;
						value_mem[pos] = val;
						held_count     = held_count + COUNT_OUT_W'(1);
						r.status       = ST_OK;
						r.slot         = pos[SLOT_W-1:0];
						break;
					end
					pos = (pos + 1) % DEPTH;
				end
			end
		end
		ACT_GET: begin
			if (held_count != 0) begin
				for (n = 0; n < DEPTH; n++) begin
					if (slot_mark[pos] == MARK_EMPTY)
						break;
					if (slot_mark[pos] == MARK_USED && key_mem[pos] == key) begin
						r.status = ST_OK;
						r.slot   = pos[SLOT_W-1:0];
						r.value  = value_mem[pos];
						break;
					end
					pos = (pos + 1) % DEPTH;
				end
			end
		end
		ACT_REMOVE: begin
			// every match in the cluster goes, not just the first
			if (held_count != 0) begin
				for (n = 0; n < DEPTH; n++) begin
					if (slot_mark[pos] == MARK_EMPTY)
						break;
					if (slot_mark[pos] == MARK_USED && key_mem[pos] == key) begin
						slot_mark[pos] = MARK_TOMB;
						held_count     = held_count - COUNT_OUT_W'(1);
						r.removed      = r.removed + COUNT_OUT_W'(1);
					end
					pos = (pos + 1) % DEPTH;
				end
			end
			if (r.removed != 0)
				r.status = ST_OK;
		end
		default: ;
		endcase
		r.held = held_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				slot_mark[i] = MARK_EMPTY;
			held_count = '0;
			load_limit = LOAD_LIMIT_RST;
			replies_due.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				load_limit = cfg_data;

			if (m_axis_tvalid && m_axis_tready) begin
				if (replies_due.size() == 0) begin
					$error("result word with no request outstanding");
					fail_count++;
				end else begin
					want        = replies_due.pop_front();
					got_slot    = m_axis_tdata[SLOT_W-1:0];
					got_value   = m_axis_tdata[SLOT_W +: VALUE_OUT_W];
					got_removed = m_axis_tdata[SLOT_W + VALUE_OUT_W +: COUNT_OUT_W];
					got_held    = m_axis_tdata[SLOT_W + VALUE_OUT_W + COUNT_OUT_W +: COUNT_OUT_W];
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
						fail_count++;
					end
					if (got_slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, got_slot);
						fail_count++;
					end
					if (got_value !== want.value) begin
						$error("value_out: expected %h, got %h", want.value, got_value);
						fail_count++;
					end
					if (got_removed !== want.removed) begin
						$error("removed_count: expected %0d, got %0d", want.removed,
							got_removed);
						fail_count++;
					end
					if (got_held !== want.held) begin
						$error("entries_held: expected %0d, got %0d", want.held, got_held);
						fail_count++;
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				replies_due.push_back(serve_request(s_axis_tuser,
					s_axis_tdata[HASH_W-1:0],
					s_axis_tdata[HASH_W +: KEY_IN_W],
					s_axis_tdata[HASH_W + KEY_IN_W +: VALUE_IN_W]));
			end

			pending = replies_due.size();
		end
	end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench top for linear_probe_hash_table_core: clock, reset, request and config stimulus.
// Checking lives in lpht_checker; depends on lpht_pkg and the core.

module tb;
	import lpht_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_SPARE   = 2'd3;   // unused action code
	localparam int unsigned         CYCLE_LIMIT = 6_000_000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [LIMIT_W-1:0]     cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata;
	logic [ACTION_W-1:0]    s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic [STATUS_W-1:0]    m_axis_tuser;
	int                     fail_count;
	int                     pending;
	logic                   no_gaps;
	int unsigned            cycle_count = 0;
	logic [31:0]            pool_key [16];
	logic [31:0]            pool_hash [16];

	linear_probe_hash_table_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	lpht_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always #10 clk = ~clk;

	always @(negedge clk)
		m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 30);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Called and returns at a falling edge; valid stays up for a back-to-back word.
	task automatic issue_request(input logic [ACTION_W-1:0] act, input logic [31:0] hash,
			input logic [31:0] key, input logic [31:0] val);
		while (!no_gaps && $urandom_range(0, 99) < 30) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {val, key, hash};
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_load_limit(input logic [LIMIT_W-1:0] lim);
		cfg_valid <= 1'b1;
		cfg_data  <= lim;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sixteen keys whose home slots crowd into a dozen slots from home onward.
	task automatic reshuffle_keys(input int home);
		logic [31:0] h;
		for (int k = 0; k < 16; k++) begin
			h = $urandom;
			h[SLOT_W-1:0] = SLOT_W'((home + $urandom_range(0, 11)) % TABLE_DEPTH_DEF);
			pool_key[k]  = $urandom;
			pool_hash[k] = h;
		end
	endtask

	task automatic mixed_request();
		int                  pick;
		int                  idx;
		logic [ACTION_W-1:0] act;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			issue_request(ACTION_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
		end else begin
			idx  = $urandom_range(0, 15);
			pick = $urandom_range(0, 99);
			if (pick < 45)
				act = ACT_PUT;
			else if (pick < 72)
				act = ACT_GET;
			else if (pick < 95)
				act = ACT_REMOVE;
			else
				act = ACT_SPARE;
			issue_request(act, pool_hash[idx], pool_key[idx], $urandom);
		end
	endtask

	task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int home, input int count,
			input logic calm);
		drain_results();
		set_load_limit(lim);
		reshuffle_keys(home);
		no_gaps <= calm;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain_results();
			mixed_request();
		end
		no_gaps <= 1'b0;
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		no_gaps       = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// load limit of one: empty table, one entry, then refused
		set_load_limit(10'd1);
		issue_request(ACT_GET,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		issue_request(ACT_REMOVE, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		issue_request(ACT_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_request(ACT_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_request(ACT_PUT,    32'h0000_0005, 32'h0000_0001, 32'h0000_0000);
		issue_request(ACT_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);

		// largest load limit: wrap past the last slot, duplicates, tombstones
		drain_results();
		set_load_limit(10'd1023);
		issue_request(ACT_PUT,    32'h0000_03FF, 32'h0000_0000, 32'h0000_0000);
		issue_request(ACT_PUT,    32'hFFFF_FFFF, 32'h0000_0000, 32'h5A5A_A5A5);
		issue_request(ACT_PUT,    32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
		issue_request(ACT_GET,    32'h0000_03FF, 32'h0000_0000, 32'h0000_0000);
		issue_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		issue_request(ACT_GET,    32'h0000_03FF, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_request(ACT_GET,    32'h0000_03FF, 32'h0000_0000, 32'h0000_0000);
		issue_request(ACT_GET,    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_request(ACT_PUT,    32'h0000_0000, 32'h0000_0007, 32'hFFFF_0000);
		issue_request(ACT_REMOVE, 32'h0000_03FF, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_request(ACT_SPARE,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		issue_request(ACT_REMOVE, 32'h0000_0000, 32'h0000_0007, 32'h0000_0000);
		issue_request(ACT_GET,    32'h0000_0000, 32'h0000_0007, 32'h0000_0000);

		// random traffic on crowded clusters under several limits
		run_phase(10'd1023, 1016, 150, 1'b0);
		run_phase(10'd12, $urandom_range(0, 1023), 100, 1'b1);
		run_phase(LIMIT_W'($urandom_range(2, 1022)), $urandom_range(0, 1023), 100, 1'b0);
		run_phase(LOAD_LIMIT_RST, $urandom_range(0, 1023), 180, 1'b0);

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

FILE: linear_probe_hash_table_core.f
sv/lpht_pkg.sv
sv/linear_probe_hash_table_core.sv
test/lpht_checker.sv
test/tb.sv
